// ----- rtl/bcb_pkg.sv -----
// Shared types, constants and arithmetic helpers for the box collision bounce block.
package bcb_pkg;

	localparam int COORD_W = 16;
	localparam int EDGE_W  = COORD_W + 1;
	localparam int DIFF_W  = EDGE_W + 1;
	localparam int DIST_W  = EDGE_W;
	localparam int ANG_W   = 13;
	localparam int ANGN_W  = 14;
	localparam int NORM_W  = 12;
	localparam int WIDE_W  = 15;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic signed [COORD_W-1:0] A_LEFT_RST   = -16'sd16;
	localparam logic signed [COORD_W-1:0] A_BOTTOM_RST = -16'sd16;
	localparam logic signed [COORD_W-1:0] A_RIGHT_RST  = 16'sd16;
	localparam logic signed [COORD_W-1:0] A_TOP_RST    = 16'sd16;

	localparam logic signed [NORM_W-1:0] NORM_RIGHT = 12'sd0;
	localparam logic signed [NORM_W-1:0] NORM_UP    = 12'sd900;
	localparam logic signed [NORM_W-1:0] NORM_LEFT  = 12'sd1800;
	localparam logic signed [NORM_W-1:0] NORM_DOWN  = -12'sd900;

	localparam logic signed [WIDE_W-1:0] REFL_LIMIT = 15'sd900;
	localparam logic signed [WIDE_W-1:0] REFL_BIAS  = 15'sd1800;

	typedef enum logic [1:0] {
		SIDE_LEFT,
		SIDE_TOP,
		SIDE_RIGHT,
		SIDE_BOTTOM
	} side_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_LEFT,
		CFG_A_BOTTOM,
		CFG_A_RIGHT,
		CFG_A_TOP
	} cfg_reg_t;

	// Overlap result and side distances for one request, handed to the bounce stage.
	typedef struct packed {
		logic                            hit;
		logic [3:0][DIST_W-1:0]          side_dist;
		logic signed [ANG_W-1:0]         a_heading;
		logic signed [ANG_W-1:0]         b_heading;
	} contact_t;

	function automatic logic corner_in(
		input logic signed [EDGE_W-1:0] px,
		input logic signed [EDGE_W-1:0] py,
		input logic signed [EDGE_W-1:0] l,
		input logic signed [EDGE_W-1:0] b,
		input logic signed [EDGE_W-1:0] r,
		input logic signed [EDGE_W-1:0] t
	);
		return (px < r) && (px > l) && (py < t) && (py > b);
	endfunction

	function automatic logic [DIST_W-1:0] abs_diff(
		input logic signed [EDGE_W-1:0] p,
		input logic signed [EDGE_W-1:0] q
	);
		logic signed [DIFF_W-1:0] diff;
		logic signed [DIFF_W-1:0] mag;
		diff = DIFF_W'(p) - DIFF_W'(q);
		mag  = diff[DIFF_W-1] ? -diff : diff;
		return mag[DIST_W-1:0];
	endfunction

	function automatic logic signed [NORM_W-1:0] norm_a(input side_t s);
		logic signed [NORM_W-1:0] n;
		case (s)
			SIDE_LEFT:   n = NORM_LEFT;
			SIDE_TOP:    n = NORM_UP;
			SIDE_RIGHT:  n = NORM_RIGHT;
			SIDE_BOTTOM: n = NORM_DOWN;
			default:     n = NORM_RIGHT;
		endcase
		return n;
	endfunction

	function automatic logic signed [NORM_W-1:0] norm_b(input side_t s);
		logic signed [NORM_W-1:0] n;
		case (s)
			SIDE_LEFT:   n = NORM_RIGHT;
			SIDE_TOP:    n = NORM_DOWN;
			SIDE_RIGHT:  n = NORM_LEFT;
			SIDE_BOTTOM: n = NORM_UP;
			default:     n = NORM_RIGHT;
		endcase
		return n;
	endfunction

	// A heading more than 90 degrees away from the normal becomes 2n - 180 - h.
	function automatic logic signed [ANGN_W-1:0] reflect(
		input logic signed [NORM_W-1:0] n,
		input logic signed [ANG_W-1:0]  h
	);
		logic signed [WIDE_W-1:0] diff;
		logic signed [WIDE_W-1:0] mag;
		logic signed [WIDE_W-1:0] bounced;
		diff    = WIDE_W'(n) - WIDE_W'(h);
		mag     = diff[WIDE_W-1] ? -diff : diff;
		bounced = (WIDE_W'(n) <<< 1) - REFL_BIAS - WIDE_W'(h);
		return (mag > REFL_LIMIT) ? bounced[ANGN_W-1:0] : ANGN_W'(h);
	endfunction

endpackage

// ----- rtl/bcb_pair_if.sv -----
// Request channel carrying one pair of boxes and their headings.
interface bcb_pair_if;
	logic                                         valid;
	logic                                         ready;
	logic signed [bcb_pkg::COORD_W-1:0]           a_pos_x;
	logic signed [bcb_pkg::COORD_W-1:0]           a_pos_y;
	logic signed [bcb_pkg::ANG_W-1:0]             a_heading;
	logic signed [bcb_pkg::COORD_W-1:0]           b_pos_x;
	logic signed [bcb_pkg::COORD_W-1:0]           b_pos_y;
	logic signed [bcb_pkg::COORD_W-1:0]           b_left_offset;
	logic signed [bcb_pkg::COORD_W-1:0]           b_bottom_offset;
	logic signed [bcb_pkg::COORD_W-1:0]           b_right_offset;
	logic signed [bcb_pkg::COORD_W-1:0]           b_top_offset;
	logic signed [bcb_pkg::ANG_W-1:0]             b_heading;
	logic                                         b_visible;

	modport source (
		output valid, a_pos_x, a_pos_y, a_heading, b_pos_x, b_pos_y, b_left_offset,
			b_bottom_offset, b_right_offset, b_top_offset, b_heading, b_visible,
		input  ready
	);

	modport sink (
		input  valid, a_pos_x, a_pos_y, a_heading, b_pos_x, b_pos_y, b_left_offset,
			b_bottom_offset, b_right_offset, b_top_offset, b_heading, b_visible,
		output ready
	);
endinterface

// ----- rtl/bcb_result_if.sv -----
// Result channel carrying the collision flag, hit side and new headings.
interface bcb_result_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  collided;
	logic [1:0]                            hit_side;
	logic signed [bcb_pkg::ANGN_W-1:0]     a_heading_new;
	logic signed [bcb_pkg::ANGN_W-1:0]     b_heading_new;

	modport source (
		output valid, collided, hit_side, a_heading_new, b_heading_new,
		input  ready
	);

	modport sink (
		input  valid, collided, hit_side, a_heading_new, b_heading_new,
		output ready
	);
endinterface

// ----- rtl/bcb_bounce.sv -----
// Nearest-side selection and heading reflection for one contact.
module bcb_bounce (
	input  bcb_pkg::contact_t                  contact,
	output logic                               collided,
	output bcb_pkg::side_t                     side,
	output logic signed [bcb_pkg::ANGN_W-1:0]  a_heading_new,
	output logic signed [bcb_pkg::ANGN_W-1:0]  b_heading_new
);

	bcb_pkg::side_t               side_lo;
	bcb_pkg::side_t               side_hi;
	bcb_pkg::side_t               side_min;
	logic [bcb_pkg::DIST_W-1:0]   dist_lo;
	logic [bcb_pkg::DIST_W-1:0]   dist_hi;

	// Ties go to the lower side number at every level of the tree.
	always_comb begin
		if (contact.side_dist[1] < contact.side_dist[0]) begin
			side_lo = bcb_pkg::SIDE_TOP;
			dist_lo = contact.side_dist[1];
		end else begin
			side_lo = bcb_pkg::SIDE_LEFT;
			dist_lo = contact.side_dist[0];
		end
		if (contact.side_dist[3] < contact.side_dist[2]) begin
			side_hi = bcb_pkg::SIDE_BOTTOM;
			dist_hi = contact.side_dist[3];
		end else begin
			side_hi = bcb_pkg::SIDE_RIGHT;
			dist_hi = contact.side_dist[2];
		end
		side_min = (dist_hi < dist_lo) ? side_hi : side_lo;
	end

	always_comb begin
		collided = contact.hit;
		if (contact.hit) begin
			side          = side_min;
			a_heading_new = bcb_pkg::reflect(bcb_pkg::norm_a(side_min), contact.a_heading);
			b_heading_new = bcb_pkg::reflect(bcb_pkg::norm_b(side_min), contact.b_heading);
		end else begin
			side          = bcb_pkg::SIDE_LEFT;
			a_heading_new = bcb_pkg::ANGN_W'(contact.a_heading);
			b_heading_new = bcb_pkg::ANGN_W'(contact.b_heading);
		end
	end

endmodule

// ----- rtl/box_collision_bounce.sv -----
// Top level: box corner-overlap test with nearest-side heading reflection.
//
//  Channel   Direction  Handshake      Contents
//  pair      in         valid/ready    both positions, B offsets, headings, B visible
//  result    out        valid/ready    collided, hit_side, both new headings
//  cfg       in         cfg_we         A edge offsets, indexed by cfg_index
//
// A request can be accepted every cycle while the result port is not stalled; its result passes
// through the input register, contact register and result register to the result port.
// arst_n clears all valid flags and loads the default A offsets.
// A stalled result holds in its register; the earlier stages keep filling until full.
module box_collision_bounce (
	input  logic                               clk,
	input  logic                               arst_n,
	bcb_pair_if.sink                           pair,
	bcb_result_if.source                       result,
	input  logic                               cfg_we,
	input  logic [bcb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bcb_pkg::CFG_W-1:0]          cfg_data
);

	logic signed [bcb_pkg::COORD_W-1:0] a_left_q;
	logic signed [bcb_pkg::COORD_W-1:0] a_bottom_q;
	logic signed [bcb_pkg::COORD_W-1:0] a_right_q;
	logic signed [bcb_pkg::COORD_W-1:0] a_top_q;

	logic                               valid_s1;
	logic signed [bcb_pkg::COORD_W-1:0] a_pos_x_s1;
	logic signed [bcb_pkg::COORD_W-1:0] a_pos_y_s1;
	logic signed [bcb_pkg::ANG_W-1:0]   a_heading_s1;
	logic signed [bcb_pkg::COORD_W-1:0] b_pos_x_s1;
	logic signed [bcb_pkg::COORD_W-1:0] b_pos_y_s1;
	logic signed [bcb_pkg::COORD_W-1:0] b_left_s1;
	logic signed [bcb_pkg::COORD_W-1:0] b_bottom_s1;
	logic signed [bcb_pkg::COORD_W-1:0] b_right_s1;
	logic signed [bcb_pkg::COORD_W-1:0] b_top_s1;
	logic signed [bcb_pkg::ANG_W-1:0]   b_heading_s1;
	logic                               b_visible_s1;

	logic                               valid_s2;
	bcb_pkg::contact_t                  contact_s2;
	bcb_pkg::contact_t                  contact_d;

	logic                               res_valid_q;
	logic                               collided_q;
	bcb_pkg::side_t                     hit_side_q;
	logic signed [bcb_pkg::ANGN_W-1:0]  a_heading_new_q;
	logic signed [bcb_pkg::ANGN_W-1:0]  b_heading_new_q;

	logic                               bounce_collided;
	bcb_pkg::side_t                     bounce_side;
	logic signed [bcb_pkg::ANGN_W-1:0]  bounce_a_heading;
	logic signed [bcb_pkg::ANGN_W-1:0]  bounce_b_heading;

	logic                               ready_res;
	logic                               ready_s2;
	logic                               ready_s1;

	logic signed [bcb_pkg::EDGE_W-1:0]  ax;
	logic signed [bcb_pkg::EDGE_W-1:0]  ay;
	logic signed [bcb_pkg::EDGE_W-1:0]  al;
	logic signed [bcb_pkg::EDGE_W-1:0]  ab;
	logic signed [bcb_pkg::EDGE_W-1:0]  ar;
	logic signed [bcb_pkg::EDGE_W-1:0]  at;
	logic signed [bcb_pkg::EDGE_W-1:0]  bl;
	logic signed [bcb_pkg::EDGE_W-1:0]  bb;
	logic signed [bcb_pkg::EDGE_W-1:0]  br;
	logic signed [bcb_pkg::EDGE_W-1:0]  bt;
	logic                               overlap;
	logic                               flat;

	assign ready_res  = !res_valid_q || result.ready;
	assign ready_s2   = !valid_s2 || ready_res;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign pair.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_left_q   <= bcb_pkg::A_LEFT_RST;
			a_bottom_q <= bcb_pkg::A_BOTTOM_RST;
			a_right_q  <= bcb_pkg::A_RIGHT_RST;
			a_top_q    <= bcb_pkg::A_TOP_RST;
		end else if (cfg_we) begin
			case (bcb_pkg::cfg_reg_t'(cfg_index))
				bcb_pkg::CFG_A_LEFT:   a_left_q   <= cfg_data;
				bcb_pkg::CFG_A_BOTTOM: a_bottom_q <= cfg_data;
				bcb_pkg::CFG_A_RIGHT:  a_right_q  <= cfg_data;
				bcb_pkg::CFG_A_TOP:    a_top_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= pair.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_res) begin
				res_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && pair.valid) begin
			a_pos_x_s1   <= pair.a_pos_x;
			a_pos_y_s1   <= pair.a_pos_y;
			a_heading_s1 <= pair.a_heading;
			b_pos_x_s1   <= pair.b_pos_x;
			b_pos_y_s1   <= pair.b_pos_y;
			b_left_s1    <= pair.b_left_offset;
			b_bottom_s1  <= pair.b_bottom_offset;
			b_right_s1   <= pair.b_right_offset;
			b_top_s1     <= pair.b_top_offset;
			b_heading_s1 <= pair.b_heading;
			b_visible_s1 <= pair.b_visible;
		end
		if (ready_s2 && valid_s1) begin
			contact_s2 <= contact_d;
		end
		if (ready_res && valid_s2) begin
			collided_q      <= bounce_collided;
			hit_side_q      <= bounce_side;
			a_heading_new_q <= bounce_a_heading;
			b_heading_new_q <= bounce_b_heading;
		end
	end

	always_comb begin
		ax = bcb_pkg::EDGE_W'(a_pos_x_s1);
		ay = bcb_pkg::EDGE_W'(a_pos_y_s1);
		al = ax + bcb_pkg::EDGE_W'(a_left_q);
		ab = ay + bcb_pkg::EDGE_W'(a_bottom_q);
		ar = ax + bcb_pkg::EDGE_W'(a_right_q);
		at = ay + bcb_pkg::EDGE_W'(a_top_q);
		bl = bcb_pkg::EDGE_W'(b_pos_x_s1) + bcb_pkg::EDGE_W'(b_left_s1);
		bb = bcb_pkg::EDGE_W'(b_pos_y_s1) + bcb_pkg::EDGE_W'(b_bottom_s1);
		br = bcb_pkg::EDGE_W'(b_pos_x_s1) + bcb_pkg::EDGE_W'(b_right_s1);
		bt = bcb_pkg::EDGE_W'(b_pos_y_s1) + bcb_pkg::EDGE_W'(b_top_s1);

		overlap = bcb_pkg::corner_in(al, ab, bl, bb, br, bt) ||
			bcb_pkg::corner_in(al, at, bl, bb, br, bt) ||
			bcb_pkg::corner_in(ar, at, bl, bb, br, bt) ||
			bcb_pkg::corner_in(ar, ab, bl, bb, br, bt) ||
			bcb_pkg::corner_in(bl, bb, al, ab, ar, at) ||
			bcb_pkg::corner_in(bl, bt, al, ab, ar, at) ||
			bcb_pkg::corner_in(br, bt, al, ab, ar, at) ||
			bcb_pkg::corner_in(br, bb, al, ab, ar, at);

		// When B has zero width, the top and bottom sides are measured along x.
		flat = (bl == br);

		contact_d.hit          = b_visible_s1 && overlap;
		contact_d.side_dist[0] = bcb_pkg::abs_diff(ax, bl);
		contact_d.side_dist[1] = flat ? bcb_pkg::abs_diff(ax, br) : bcb_pkg::abs_diff(ay, bt);
		contact_d.side_dist[2] = bcb_pkg::abs_diff(ax, br);
		contact_d.side_dist[3] = flat ? bcb_pkg::abs_diff(ax, bl) : bcb_pkg::abs_diff(ay, bb);
		contact_d.a_heading    = a_heading_s1;
		contact_d.b_heading    = b_heading_s1;
	end

	bcb_bounce u_bounce (
		.contact       (contact_s2),
		.collided      (bounce_collided),
		.side          (bounce_side),
		.a_heading_new (bounce_a_heading),
		.b_heading_new (bounce_b_heading)
	);

	assign result.valid         = res_valid_q;
	assign result.collided      = collided_q;
	assign result.hit_side      = hit_side_q;
	assign result.a_heading_new = a_heading_new_q;
	assign result.b_heading_new = b_heading_new_q;

endmodule

// ----- rtl/bcb_checker.sv -----
// Port-level checks for the box collision bounce block, bound to its top level.
module bcb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          collided,
	input logic [1:0]                    hit_side,
	input logic [bcb_pkg::ANGN_W-1:0]    a_heading_new,
	input logic [bcb_pkg::ANGN_W-1:0]    b_heading_new
);

	localparam int TOP = bcb_pkg::ANGN_W - 1;

	// A stalled result keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(collided) &&
			$stable(hit_side) && $stable(a_heading_new) && $stable(b_heading_new))
		else $error("result changed while stalled");

	// Without a collision, the side field reads as the left side.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !collided |-> hit_side == bcb_pkg::SIDE_LEFT)
		else $error("hit side set without a collision");

	// Without a collision, A's heading passes through and so fits the request width.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !collided |-> a_heading_new[TOP] == a_heading_new[TOP-1])
		else $error("A heading changed without a collision");

	// Without a collision, B's heading passes through and so fits the request width.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !collided |-> b_heading_new[TOP] == b_heading_new[TOP-1])
		else $error("B heading changed without a collision");

endmodule

bind box_collision_bounce bcb_checker u_bcb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.collided      (result.collided),
	.hit_side      (result.hit_side),
	.a_heading_new (result.a_heading_new),
	.b_heading_new (result.b_heading_new)
);

// ----- tb/sv/tb_box_collision_bounce.sv -----
// Self-checking testbench for box_collision_bounce: random and directed box pairs with a predictor.
`timescale 1ns / 100ps

module tb_box_collision_bounce;

	localparam int DEG90        = 900;
	localparam int DEG180       = 1800;
	localparam int QUIET_LIMIT  = 4000;
	localparam int RX_HOLD_LEN  = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int HEADING_PICKS [15] = '{0, 899, 900, 901, -899, -900, -901, 1800, -1800,
		2700, -2701, 3600, -3600, 4095, -4096};

	typedef struct {
		logic signed [bcb_pkg::COORD_W-1:0] a_pos_x;
		logic signed [bcb_pkg::COORD_W-1:0] a_pos_y;
		logic signed [bcb_pkg::ANG_W-1:0]   a_heading;
		logic signed [bcb_pkg::COORD_W-1:0] b_pos_x;
		logic signed [bcb_pkg::COORD_W-1:0] b_pos_y;
		logic signed [bcb_pkg::COORD_W-1:0] b_left_offset;
		logic signed [bcb_pkg::COORD_W-1:0] b_bottom_offset;
		logic signed [bcb_pkg::COORD_W-1:0] b_right_offset;
		logic signed [bcb_pkg::COORD_W-1:0] b_top_offset;
		logic signed [bcb_pkg::ANG_W-1:0]   b_heading;
		logic                               b_visible;
	} box_pair_t;

	typedef struct {
		logic                               collided;
		bcb_pkg::side_t                     hit_side;
		logic signed [bcb_pkg::ANGN_W-1:0]  a_heading_new;
		logic signed [bcb_pkg::ANGN_W-1:0]  b_heading_new;
	} bounce_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [bcb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bcb_pkg::CFG_W-1:0] cfg_data;

	bcb_pair_if pair_ch ();
	bcb_result_if res_ch ();

	box_collision_bounce u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic signed [bcb_pkg::CFG_W-1:0] a_offset [4];
	box_pair_t pending_requests [$];
	bounce_t expected_bounces [$];
	box_pair_t next_request;
	box_pair_t seen_request;
	bounce_t want;
	bit request_taken;
	bit rx_hold_req;
	int rx_hold_left;
	int src_idle_pct;
	int rx_idle_pct;
	int requests_queued;
	int results_seen;
	int mismatches;
	int collisions;
	int side_hits [4];
	int offset_settings;
	int quiet_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int magnitude(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic bit strictly_inside(int px, int py, int l, int b, int r, int t);
		return (px > l) && (px < r) && (py > b) && (py < t);
	endfunction

	function automatic int bounce_heading(int normal, int heading);
		if (magnitude(normal - heading) > DEG90)
			return 2 * normal - DEG180 - heading;
		return heading;
	endfunction

	function automatic bounce_t predict_bounce(box_pair_t p);
		int ax, ay, bx, by;
		int al, ab, ar, at, bl, bb, br, bt;
		int gap [4];
		int na, nb;
		bcb_pkg::side_t nearest;
		bounce_t r;
		ax = p.a_pos_x;
		ay = p.a_pos_y;
		bx = p.b_pos_x;
		by = p.b_pos_y;
		al = ax + int'(a_offset[bcb_pkg::CFG_A_LEFT]);
		ab = ay + int'(a_offset[bcb_pkg::CFG_A_BOTTOM]);
		ar = ax + int'(a_offset[bcb_pkg::CFG_A_RIGHT]);
		at = ay + int'(a_offset[bcb_pkg::CFG_A_TOP]);
		bl = bx + int'(p.b_left_offset);
		bb = by + int'(p.b_bottom_offset);
		br = bx + int'(p.b_right_offset);
		bt = by + int'(p.b_top_offset);
		r.collided = p.b_visible && (
			strictly_inside(al, ab, bl, bb, br, bt) || strictly_inside(al, at, bl, bb, br, bt) ||
			strictly_inside(ar, at, bl, bb, br, bt) || strictly_inside(ar, ab, bl, bb, br, bt) ||
			strictly_inside(bl, bb, al, ab, ar, at) || strictly_inside(bl, bt, al, ab, ar, at) ||
			strictly_inside(br, bt, al, ab, ar, at) || strictly_inside(br, bb, al, ab, ar, at));
		r.hit_side = bcb_pkg::SIDE_LEFT;
		r.a_heading_new = bcb_pkg::ANGN_W'(int'(p.a_heading));
		r.b_heading_new = bcb_pkg::ANGN_W'(int'(p.b_heading));
		if (r.collided) begin
			// With B's left and right edges on one line, top and bottom measure along x.
			gap[bcb_pkg::SIDE_LEFT]   = magnitude(ax - bl);
			gap[bcb_pkg::SIDE_TOP]    = (bl != br) ? magnitude(ay - bt) : magnitude(ax - br);
			gap[bcb_pkg::SIDE_RIGHT]  = magnitude(ax - br);
			gap[bcb_pkg::SIDE_BOTTOM] = (bl != br) ? magnitude(ay - bb) : magnitude(ax - bl);
			nearest = bcb_pkg::SIDE_LEFT;
			for (int i = 1; i < 4; i++)
				if (gap[i] < gap[nearest])
					nearest = bcb_pkg::side_t'(i);
			case (nearest)
				bcb_pkg::SIDE_LEFT: begin
					na = DEG180;
					nb = 0;
				end
				bcb_pkg::SIDE_TOP: begin
					na = DEG90;
					nb = -DEG90;
				end
				bcb_pkg::SIDE_RIGHT: begin
					na = 0;
					nb = DEG180;
				end
				default: begin
					na = -DEG90;
					nb = DEG90;
				end
			endcase
			r.hit_side = nearest;
			r.a_heading_new = bcb_pkg::ANGN_W'(bounce_heading(na, p.a_heading));
			r.b_heading_new = bcb_pkg::ANGN_W'(bounce_heading(nb, p.b_heading));
		end
		return r;
	endfunction

	function automatic box_pair_t make_pair(int ax, int ay, int ah, int bx, int by,
		int bl, int bb, int br, int bt, int bh, int vis);
		box_pair_t p;
		p.a_pos_x = bcb_pkg::COORD_W'(ax);
		p.a_pos_y = bcb_pkg::COORD_W'(ay);
		p.a_heading = bcb_pkg::ANG_W'(ah);
		p.b_pos_x = bcb_pkg::COORD_W'(bx);
		p.b_pos_y = bcb_pkg::COORD_W'(by);
		p.b_left_offset = bcb_pkg::COORD_W'(bl);
		p.b_bottom_offset = bcb_pkg::COORD_W'(bb);
		p.b_right_offset = bcb_pkg::COORD_W'(br);
		p.b_top_offset = bcb_pkg::COORD_W'(bt);
		p.b_heading = bcb_pkg::ANG_W'(bh);
		p.b_visible = vis[0];
		return p;
	endfunction

	function automatic int pick_heading();
		if ($urandom_range(3) == 0)
			return HEADING_PICKS[$urandom_range(14)];
		return int'($urandom);
	endfunction

	function automatic int offset_within(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// Most pairs sit close together so that collisions and every side come up often.
	function automatic box_pair_t random_pair(int span);
		box_pair_t p;
		int ax, ay, bl, br;
		ax = int'($urandom);
		ay = int'($urandom);
		if ($urandom_range(99) < 25) begin
			p = make_pair(ax, ay, pick_heading(), $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, pick_heading(), $urandom_range(1));
		end else begin
			bl = -int'($urandom_range(span));
			br = $urandom_range(9) == 0 ? bl : int'($urandom_range(span));
			p = make_pair(ax, ay, pick_heading(), ax + offset_within(span),
				ay + offset_within(span), bl, -int'($urandom_range(span)), br,
				$urandom_range(span), pick_heading(), $urandom_range(9) != 0);
		end
		return p;
	endfunction

	task automatic offer(box_pair_t p);
		pending_requests.push_back(p);
		requests_queued++;
	endtask

	task automatic offer_random(int count, int span);
		repeat (count)
			offer(random_pair(span));
	endtask

	task automatic wait_drained();
		while (results_seen != requests_queued)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_offset(bcb_pkg::cfg_reg_t idx, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= bcb_pkg::CFG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		a_offset[idx] = bcb_pkg::CFG_W'(value);
	endtask

	task automatic set_offsets(int l, int b, int r, int t);
		write_offset(bcb_pkg::CFG_A_LEFT, l);
		write_offset(bcb_pkg::CFG_A_BOTTOM, b);
		write_offset(bcb_pkg::CFG_A_RIGHT, r);
		write_offset(bcb_pkg::CFG_A_TOP, t);
		offset_settings++;
	endtask

	task automatic report_mismatch(string field, int got, int expected);
		$display("mismatch at result %0d, %s: got %0d, expected %0d",
			results_seen, field, got, expected);
		mismatches++;
	endtask

	always @(negedge clk) begin
		if (arst_n !== 1'b1) begin
			pair_ch.valid <= 1'b0;
		end else if (request_taken || !pair_ch.valid) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				next_request = pending_requests.pop_front();
				pair_ch.a_pos_x <= next_request.a_pos_x;
				pair_ch.a_pos_y <= next_request.a_pos_y;
				pair_ch.a_heading <= next_request.a_heading;
				pair_ch.b_pos_x <= next_request.b_pos_x;
				pair_ch.b_pos_y <= next_request.b_pos_y;
				pair_ch.b_left_offset <= next_request.b_left_offset;
				pair_ch.b_bottom_offset <= next_request.b_bottom_offset;
				pair_ch.b_right_offset <= next_request.b_right_offset;
				pair_ch.b_top_offset <= next_request.b_top_offset;
				pair_ch.b_heading <= next_request.b_heading;
				pair_ch.b_visible <= next_request.b_visible;
				pair_ch.valid <= 1'b1;
			end else begin
				pair_ch.valid <= 1'b0;
			end
		end
		request_taken = 1'b0;
	end

	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_left = RX_HOLD_LEN;
			rx_hold_req = 1'b0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pair_ch.valid && pair_ch.ready) begin
				seen_request.a_pos_x = pair_ch.a_pos_x;
				seen_request.a_pos_y = pair_ch.a_pos_y;
				seen_request.a_heading = pair_ch.a_heading;
				seen_request.b_pos_x = pair_ch.b_pos_x;
				seen_request.b_pos_y = pair_ch.b_pos_y;
				seen_request.b_left_offset = pair_ch.b_left_offset;
				seen_request.b_bottom_offset = pair_ch.b_bottom_offset;
				seen_request.b_right_offset = pair_ch.b_right_offset;
				seen_request.b_top_offset = pair_ch.b_top_offset;
				seen_request.b_heading = pair_ch.b_heading;
				seen_request.b_visible = pair_ch.b_visible;
				expected_bounces.push_back(predict_bounce(seen_request));
				request_taken = 1'b1;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_bounces.size() == 0) begin
					report_mismatch("unexpected result", int'(res_ch.collided), 0);
				end else begin
					want = expected_bounces.pop_front();
					if (res_ch.collided !== want.collided)
						report_mismatch("collided", int'(res_ch.collided), int'(want.collided));
					if (res_ch.hit_side !== want.hit_side)
						report_mismatch("hit_side", int'(res_ch.hit_side), int'(want.hit_side));
					if (res_ch.a_heading_new !== want.a_heading_new)
						report_mismatch("a_heading_new", int'(res_ch.a_heading_new),
							int'(want.a_heading_new));
					if (res_ch.b_heading_new !== want.b_heading_new)
						report_mismatch("b_heading_new", int'(res_ch.b_heading_new),
							int'(want.b_heading_new));
					if (want.collided) begin
						collisions++;
						side_hits[want.hit_side]++;
					end
				end
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no request or result moved for %0d cycles", quiet_cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		cfg_we = 1'b0;
		cfg_index = bcb_pkg::CFG_A_LEFT;
		cfg_data = '0;
		pair_ch.valid = 1'b0;
		pair_ch.a_pos_x = '0;
		pair_ch.a_pos_y = '0;
		pair_ch.a_heading = '0;
		pair_ch.b_pos_x = '0;
		pair_ch.b_pos_y = '0;
		pair_ch.b_left_offset = '0;
		pair_ch.b_bottom_offset = '0;
		pair_ch.b_right_offset = '0;
		pair_ch.b_top_offset = '0;
		pair_ch.b_heading = '0;
		pair_ch.b_visible = 1'b0;
		res_ch.ready = 1'b0;
		a_offset[bcb_pkg::CFG_A_LEFT] = bcb_pkg::A_LEFT_RST;
		a_offset[bcb_pkg::CFG_A_BOTTOM] = bcb_pkg::A_BOTTOM_RST;
		a_offset[bcb_pkg::CFG_A_RIGHT] = bcb_pkg::A_RIGHT_RST;
		a_offset[bcb_pkg::CFG_A_TOP] = bcb_pkg::A_TOP_RST;
		offset_settings = 1;
		src_idle_pct = 15;
		rx_idle_pct = 64;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		offer(make_pair(0, 0, 0, 8, 8, -16, -16, 16, 16, 1800, 0));
		offer(make_pair(0, 0, 450, 0, 0, -16, -16, 16, 16, -450, 1));
		offer(make_pair(0, 0, 0, 24, 4, -16, -16, 16, 16, 1800, 1));
		offer(make_pair(0, 0, 900, 4, 24, -16, -16, 16, 16, -900, 1));
		offer(make_pair(0, 0, -900, 4, -24, -16, -16, 16, 16, 900, 1));
		offer(make_pair(0, 0, 1800, -24, 4, -16, -16, 16, 16, 0, 1));
		offer(make_pair(0, 0, 0, 8, 8, -16, -16, 16, 16, 0, 1));
		offer(make_pair(0, 0, 900, 0, 0, -40, -40, 40, 40, 900, 1));
		offer(make_pair(0, 0, 900, 4, 0, 0, -4, 0, 4, -900, 1));
		offer(make_pair(0, 0, 2700, -4, 0, 0, -4, 0, 4, 2700, 1));
		offer(make_pair(0, 0, 900, 24, 4, -16, -16, 16, 16, -900, 1));
		offer(make_pair(0, 0, 899, 24, 4, -16, -16, 16, 16, -901, 1));
		offer(make_pair(0, 0, 4095, 24, 4, -16, -16, 16, 16, -4096, 1));
		offer(make_pair(0, 0, -4096, 4, 24, -16, -16, 16, 16, 4095, 1));
		offer(make_pair(0, 0, 3600, -24, 4, -16, -16, 16, 16, -3600, 1));
		offer(make_pair(32767, 32767, 0, 32767, 32767, -32768, -32768, 32767, 32767, 0, 1));
		offer(make_pair(-32768, -32768, -3600, -32768, -32768, 32767, 32767, -32768, -32768,
			3600, 1));
		offer(make_pair(32767, -32768, 4095, -32768, 32767, 32767, -32768, 32767, -32768,
			-4096, 1));
		offer(make_pair(0, 0, 100, 1000, 1000, -16, -16, 16, 16, -100, 1));
		offer(make_pair(100, -50, 2700, 90, -40, -20, -5, 30, 8, -2700, 1));
		offer_random(60, 48);
		wait_drained();

		set_offsets(-int'($urandom_range(48)), -int'($urandom_range(48)),
			$urandom_range(48), $urandom_range(48));
		@(posedge clk);
		rx_hold_req = 1'b1;
		offer_random(60, 96);
		wait_drained();

		src_idle_pct = 64;
		rx_idle_pct = 15;
		set_offsets(-32768, -32768, 32767, 32767);
		offer_random(50, 48);
		wait_drained();
		set_offsets(32767, 32767, -32768, -32768);
		offer_random(40, 48);
		wait_drained();

		src_idle_pct = 0;
		rx_idle_pct = 0;
		set_offsets(0, 0, 0, 0);
		offer_random(40, 16);
		wait_drained();
		set_offsets($urandom, $urandom, $urandom, $urandom);
		offer_random(60, 4096);
		wait_drained();
		set_offsets(bcb_pkg::A_LEFT_RST, bcb_pkg::A_BOTTOM_RST, bcb_pkg::A_RIGHT_RST,
			bcb_pkg::A_TOP_RST);
		offer_random(60, 48);
		wait_drained();

		repeat (10) @(posedge clk);
		if (expected_bounces.size() != 0)
			report_mismatch("results never delivered", expected_bounces.size(), 0);
		$display("Checked %0d requests under %0d offset settings and three stall patterns.",
			results_seen, offset_settings);
		$display("Collisions %0d (left %0d, top %0d, right %0d, bottom %0d), mismatches %0d.",
			collisions, side_hits[bcb_pkg::SIDE_LEFT], side_hits[bcb_pkg::SIDE_TOP],
			side_hits[bcb_pkg::SIDE_RIGHT], side_hits[bcb_pkg::SIDE_BOTTOM], mismatches);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
